@@ rtl/core/binary_grid_neighbour_count_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid neighbor count block
// Clocked property checks on one clock; only the first is quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_GRID_NEIGHBOUR_COUNT_TOP_ASSERT_SVH
`define BINARY_GRID_NEIGHBOUR_COUNT_TOP_ASSERT_SVH

// Check on clk, quiet while rst_n is low.
`define BGNC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on clk at every edge, reset included.
`define BGNC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bgnc_pkg.sv @@
// ----------------------------------------------------------------------------
// bgnc_pkg
// Widths, register indexes and control types shared by the block's files.
// ----------------------------------------------------------------------------
package bgnc_pkg;

    localparam int MAX_COLS_DEFAULT = 32;
    localparam int MAX_ROWS_DEFAULT = 4096;

    localparam int NUM_ROWS_W  = 13;
    localparam int NUM_COLS_W  = 6;
    localparam int COUNT_W     = 4;
    localparam int ROW_OUT_W   = 12;
    localparam int COL_OUT_W   = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RESET = 13'd1;
    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RESET = 6'd1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 2'd1;

    typedef struct packed {
        logic accept;   // take the cell beat, update stores, start a run
        logic emit;     // load the next result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_results;  // the offered cell releases at least one result
        logic run_last;     // the pending step is the last of its run
        logic out_free;     // the output register can take a result
    } dp_status_t;

endpackage

@@ rtl/core/bgnc_cell_if.sv @@
// ----------------------------------------------------------------------------
// bgnc_cell_if
// Input channel: one grid cell per beat.
// ----------------------------------------------------------------------------
interface bgnc_cell_if;
    logic valid;
    logic ready;
    logic mine;

    modport source (output valid, output mine, input ready);
    modport sink (input valid, input mine, output ready);
endinterface

@@ rtl/core/bgnc_count_if.sv @@
// ----------------------------------------------------------------------------
// bgnc_count_if
// Output channel: one neighbor count with its cell position per beat.
// ----------------------------------------------------------------------------
interface bgnc_count_if;
    logic                           valid;
    logic                           ready;
    logic [bgnc_pkg::COUNT_W-1:0]   neighbour_count;
    logic [bgnc_pkg::ROW_OUT_W-1:0] cell_row;
    logic [bgnc_pkg::COL_OUT_W-1:0] cell_col;
    logic                           last_of_run;
    logic                           frame_end;

    modport source (output valid, output neighbour_count, output cell_row,
                    output cell_col, output last_of_run, output frame_end,
                    input ready);
    modport sink (input valid, input neighbour_count, input cell_row,
                  input cell_col, input last_of_run, input frame_end,
                  output ready);
endinterface

@@ rtl/core/bgnc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bgnc_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface bgnc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bgnc_pkg::CFG_INDEX_W-1:0] index;
    logic [bgnc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/binary_grid_neighbour_count_top.sv @@
// Counts set cells in the clipped 3x3 box around every cell of a binary grid
// streamed one cell per beat in row-major order, and returns the counts in
// row-major order with their positions as soon as each is final. A cell that
// releases no result or one result is taken without holding off the next, so
// ordinary cells stream at one per clock while the receiver keeps up. At the
// last column of a row the block releases the tail of the row above, and the
// frame's last cell also releases the whole last row; the next cell is held
// off while such a run drains, since the single output register hands out one
// result per cycle when the receiver is ready. Receiver stalls hold the run.
// The row stores are flip-flops cleared by reset, so no start-up pass is needed.
// ----------------------------------------------------------------------------
// binary_grid_neighbour_count_top
// Top level: sequencer, datapath and interface channels.
// ----------------------------------------------------------------------------
`include "binary_grid_neighbour_count_top_assert.svh"

module binary_grid_neighbour_count_top
#(
    parameter int MAX_COLS = bgnc_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = bgnc_pkg::MAX_ROWS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    bgnc_cell_if.sink    cells,
    bgnc_count_if.source counts,
    bgnc_cfg_if.sink     cfg
);

    bgnc_pkg::ctrl_cmd_t  cmd;
    bgnc_pkg::dp_status_t status;
    logic                 cell_ready;
    logic                 fend_beat;
    logic                 run_start;

    assign cells.ready = cell_ready;

    bgnc_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cells.valid),
        .cell_ready (cell_ready),
        .status     (status),
        .cmd        (cmd)
    );

    bgnc_datapath
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .mine   (cells.mine),
        .cfg    (cfg),
        .counts (counts)
    );

    assign fend_beat = counts.valid && counts.frame_end;
    assign run_start = cmd.accept && status.has_results;

    `BGNC_ASSERT(a_frame_end_closes_run, fend_beat |-> counts.last_of_run, "frame end off run end")
    `BGNC_ASSERT(a_run_reaches_output, run_start |-> ##2 counts.valid, "run without output beat")
    `BGNC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !counts.valid, "output valid during reset")

endmodule

@@ rtl/core/bgnc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bgnc_ctrl
// Sequencer: takes cell beats and steps the datapath through each result run.
// ----------------------------------------------------------------------------
module bgnc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    output logic                 cell_ready,
    input  bgnc_pkg::dp_status_t status,
    output bgnc_pkg::ctrl_cmd_t  cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EMIT = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       emit;
    logic       accept;

    assign emit   = (state_reg == ST_EMIT) && status.out_free;
    // take the next cell on the same edge that the run's last result leaves
    assign cell_ready = (state_reg == ST_IDLE) || (emit && status.run_last);
    assign accept = cell_valid && cell_ready;

    assign cmd.accept = accept;
    assign cmd.emit   = emit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.has_results)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit && status.run_last)
                    state_next = (accept && status.has_results) ? ST_EMIT : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/bgnc_datapath.sv @@
// ----------------------------------------------------------------------------
// bgnc_datapath
// Row stores, position counters, run bookkeeping, window sums and the
// output register.
// ----------------------------------------------------------------------------
module bgnc_datapath
#(
    parameter int MAX_COLS = bgnc_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = bgnc_pkg::MAX_ROWS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bgnc_pkg::ctrl_cmd_t  cmd,
    output bgnc_pkg::dp_status_t status,
    input  logic                 mine,
    bgnc_cfg_if.sink             cfg,
    bgnc_count_if.source         counts
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = ((RW > bgnc_pkg::NUM_ROWS_W) ? RW : bgnc_pkg::NUM_ROWS_W) + 1;
    localparam int CLW = (((CCW + 1) > bgnc_pkg::NUM_COLS_W) ? (CCW + 1)
                                                           : bgnc_pkg::NUM_COLS_W) + 1;

    // configuration
    logic [bgnc_pkg::NUM_ROWS_W-1:0] num_rows_reg;
    logic [bgnc_pkg::NUM_COLS_W-1:0] num_cols_reg;
    logic [RCW-1:0]                  rows_raw;
    logic [RCW-1:0]                  rows_eff;
    logic [CLW-1:0]                  cols_raw;
    logic [CLW-1:0]                  cols_eff;
    logic [CCW-1:0]                  cols_m1;

    // stores and position
    logic [MAX_COLS-1:0] upper_reg;
    logic [MAX_COLS-1:0] middle_reg;
    logic [MAX_COLS-1:0] current_reg;
    logic [MAX_COLS-1:0] current_next;
    logic [RW-1:0]       in_row_reg;
    logic [CCW-1:0]      in_col_reg;

    // release decode for the offered cell
    logic           last_col;
    logic           last_row;
    logic [CCW-1:0] col_prev;
    logic           a_en;
    logic           b_en;
    logic [CCW-1:0] a_lo;
    logic [CCW-1:0] a_hi;

    // run state
    logic           phase_b_reg;
    logic [CCW-1:0] k_reg;
    logic [CCW-1:0] a_hi_reg;
    logic           b_en_reg;
    logic           up_ok_reg;
    logic           above_b_reg;
    logic [RW-1:0]  run_row_reg;

    // window sums
    logic [MAX_COLS-1:0]        col_mask;
    logic [MAX_COLS-1:0]        top_bits;
    logic [MAX_COLS-1:0]        mid_bits;
    logic [MAX_COLS-1:0]        bot_bits;
    logic [1:0]                 vsum [MAX_COLS+1:0];
    logic [bgnc_pkg::COUNT_W-1:0] win [MAX_COLS-1:0];
    logic [RW-1:0]              out_row;
    logic                       frame_last;

    // output register
    logic                           out_valid_reg;
    logic [bgnc_pkg::COUNT_W-1:0]   count_reg;
    logic [bgnc_pkg::ROW_OUT_W-1:0] row_reg;
    logic [bgnc_pkg::COL_OUT_W-1:0] col_reg;
    logic                           last_reg;
    logic                           fend_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= bgnc_pkg::NUM_ROWS_RESET;
            num_cols_reg <= bgnc_pkg::NUM_COLS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == bgnc_pkg::REG_NUM_ROWS)
                num_rows_reg <= cfg.data[bgnc_pkg::NUM_ROWS_W-1:0];
            else if (cfg.index == bgnc_pkg::REG_NUM_COLS)
                num_cols_reg <= cfg.data[bgnc_pkg::NUM_COLS_W-1:0];
        end
    end

    // clamp the programmed sizes to 1..MAX
    always_comb
    begin
        rows_raw = RCW'(num_rows_reg);
        if (rows_raw == '0)
            rows_eff = RCW'(1);
        else if (rows_raw > RCW'(MAX_ROWS))
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = rows_raw;

        cols_raw = CLW'(num_cols_reg);
        if (cols_raw == '0)
            cols_eff = CLW'(1);
        else if (cols_raw > CLW'(MAX_COLS))
            cols_eff = CLW'(MAX_COLS);
        else
            cols_eff = cols_raw;

        cols_m1 = CCW'(cols_eff - CLW'(1));
    end

    always_comb
    begin
        last_col = (CLW'(in_col_reg) + CLW'(1)) >= cols_eff;
        last_row = (RCW'(in_row_reg) + RCW'(1)) >= rows_eff;
        col_prev = (in_col_reg == '0) ? '0 : in_col_reg - CCW'(1);
        a_en     = (in_row_reg != '0) && (last_col || (in_col_reg != '0));
        b_en     = last_row && last_col;
        if (last_col)
        begin
            a_lo = (col_prev > cols_m1) ? cols_m1 : col_prev;
            a_hi = cols_m1;
        end
        else
        begin
            a_lo = col_prev;
            a_hi = col_prev;
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_COLS; j++)
            current_next[j] = (CCW'(j) == in_col_reg) ? mine : current_reg[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg   <= '0;
            middle_reg  <= '0;
            current_reg <= '0;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            // shift the row stores at the start of a row
            if (in_col_reg == '0)
            begin
                upper_reg  <= middle_reg;
                middle_reg <= current_reg;
            end
            current_reg <= current_next;
            if (last_col)
            begin
                in_col_reg <= '0;
                in_row_reg <= last_row ? '0 : in_row_reg + RW'(1);
            end
            else
            begin
                in_col_reg <= in_col_reg + CCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_b_reg <= 1'b0;
            k_reg       <= '0;
            a_hi_reg    <= '0;
            b_en_reg    <= 1'b0;
            up_ok_reg   <= 1'b0;
            above_b_reg <= 1'b0;
            run_row_reg <= '0;
        end
        else if (cmd.accept)
        begin
            phase_b_reg <= !a_en;
            k_reg       <= a_en ? a_lo : '0;
            a_hi_reg    <= a_hi;
            b_en_reg    <= b_en;
            up_ok_reg   <= RCW'(in_row_reg) >= RCW'(2);
            above_b_reg <= in_row_reg != '0;
            run_row_reg <= in_row_reg;
        end
        else if (cmd.emit)
        begin
            // row above done: move on to the final row
            if (!phase_b_reg && (k_reg == a_hi_reg))
            begin
                phase_b_reg <= 1'b1;
                k_reg       <= '0;
            end
            else
            begin
                k_reg <= k_reg + CCW'(1);
            end
        end
    end

    // column sums of the three window rows, then the 3-wide sum per column
    always_comb
    begin
        for (int j = 0; j < MAX_COLS; j++)
            col_mask[j] = CLW'(j) < cols_eff;

        if (phase_b_reg)
        begin
            top_bits = middle_reg & {MAX_COLS{above_b_reg}};
            mid_bits = current_reg;
            bot_bits = '0;
        end
        else
        begin
            top_bits = upper_reg & {MAX_COLS{up_ok_reg}};
            mid_bits = middle_reg;
            bot_bits = current_reg;
        end
        top_bits = top_bits & col_mask;
        mid_bits = mid_bits & col_mask;
        bot_bits = bot_bits & col_mask;

        vsum[0]          = 2'd0;
        vsum[MAX_COLS+1] = 2'd0;
        for (int j = 0; j < MAX_COLS; j++)
            vsum[j+1] = {1'b0, top_bits[j]} + {1'b0, mid_bits[j]} + {1'b0, bot_bits[j]};

        for (int j = 0; j < MAX_COLS; j++)
            win[j] = bgnc_pkg::COUNT_W'(vsum[j]) + bgnc_pkg::COUNT_W'(vsum[j+1])
                   + bgnc_pkg::COUNT_W'(vsum[j+2]);
    end

    assign out_row    = phase_b_reg ? run_row_reg : run_row_reg - RW'(1);
    assign frame_last = phase_b_reg && (k_reg == cols_m1);

    assign status.has_results = a_en || b_en;
    assign status.run_last    = phase_b_reg ? (k_reg == cols_m1)
                                            : ((k_reg == a_hi_reg) && !b_en_reg);
    assign status.out_free    = !out_valid_reg || counts.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (counts.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            count_reg <= win[k_reg];
            row_reg   <= bgnc_pkg::ROW_OUT_W'(out_row);
            col_reg   <= bgnc_pkg::COL_OUT_W'(k_reg);
            last_reg  <= status.run_last;
            fend_reg  <= frame_last;
        end
    end

    assign counts.valid           = out_valid_reg;
    assign counts.neighbour_count = count_reg;
    assign counts.cell_row        = row_reg;
    assign counts.cell_col        = col_reg;
    assign counts.last_of_run     = last_reg;
    assign counts.frame_end       = fend_reg;

endmodule

@@ test/bgnc_box_sum_checker.sv @@
// ----------------------------------------------------------------------------
// bgnc_box_sum_checker
// Watches the cell, count and register channels. For every accepted cell it
// computes the 3x3 box sums that the cell releases and queues them. Each
// count beat is compared field by field with the oldest queued sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bgnc_box_sum_checker
#(
    parameter int GRID_COLS = bgnc_pkg::MAX_COLS_DEFAULT,
    parameter int GRID_ROWS = bgnc_pkg::MAX_ROWS_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    bgnc_cell_if  cells,
    bgnc_count_if counts,
    bgnc_cfg_if   cfg,
    output int    counts_pending,
    output int    error_count
);

    typedef struct packed {
        logic [bgnc_pkg::COUNT_W-1:0]   neighbour_count;
        logic [bgnc_pkg::ROW_OUT_W-1:0] cell_row;
        logic [bgnc_pkg::COL_OUT_W-1:0] cell_col;
        logic                           last_of_run;
        logic                           frame_end;
    } count_beat_t;

    count_beat_t                     pending_counts[$];
    logic [GRID_COLS-1:0]            upper_bits;
    logic [GRID_COLS-1:0]            middle_bits;
    logic [GRID_COLS-1:0]            current_bits;
    logic [bgnc_pkg::NUM_ROWS_W-1:0] num_rows_q;
    logic [bgnc_pkg::NUM_COLS_W-1:0] num_cols_q;
    int                              next_row;
    int                              next_col;
    int                              errors;

    function automatic int row_window_sum(logic [GRID_COLS-1:0] bits, int k, int cols);
        int sum;
        sum = 0;
        for (int j = (k >= 1) ? k - 1 : 0; j <= k + 1; j++)
        begin
            if (j < cols && j < GRID_COLS)
                sum += int'(bits[bgnc_pkg::COL_OUT_W'(j)]);
        end
        return sum;
    endfunction

    function automatic int box_sum(logic [GRID_COLS-1:0] above, bit has_above,
                                   logic [GRID_COLS-1:0] here,
                                   logic [GRID_COLS-1:0] below, bit has_below,
                                   int k, int cols);
        int sum;
        sum = row_window_sum(here, k, cols);
        if (has_above)
            sum += row_window_sum(above, k, cols);
        if (has_below)
            sum += row_window_sum(below, k, cols);
        return sum;
    endfunction

    task automatic push_count(int count, int row, int col);
        count_beat_t beat;
        beat.neighbour_count = bgnc_pkg::COUNT_W'(count);
        beat.cell_row        = bgnc_pkg::ROW_OUT_W'(row);
        beat.cell_col        = bgnc_pkg::COL_OUT_W'(col);
        beat.last_of_run     = 1'b0;
        beat.frame_end       = 1'b0;
        pending_counts = {pending_counts, beat};
    endtask

    task automatic predict_box_sums(logic mine);
        int          rows;
        int          cols;
        int          r;
        int          c;
        int          lo;
        int          size_before;
        bit          last_col;
        bit          last_row;
        count_beat_t beat;
        rows = int'(num_rows_q);
        cols = int'(num_cols_q);
        if (rows < 1) rows = 1;
        if (rows > GRID_ROWS) rows = GRID_ROWS;
        if (cols < 1) cols = 1;
        if (cols > GRID_COLS) cols = GRID_COLS;
        r = next_row;
        c = next_col;
        size_before = pending_counts.size();

        // shift the row stores at the start of every row
        if (c == 0)
        begin
            upper_bits  = middle_bits;
            middle_bits = current_bits;
        end
        if (c < GRID_COLS)
            current_bits[bgnc_pkg::COL_OUT_W'(c)] = mine;

        last_col = (c + 1 >= cols);
        last_row = (r + 1 >= rows);

        // the row above is final up to the cell left of this one, or to its end at the last column
        if (r >= 1)
        begin
            if (last_col)
            begin
                lo = (c >= 1) ? c - 1 : 0;
                if (lo > cols - 1) lo = cols - 1;
                for (int k = lo; k < cols; k++)
                    push_count(box_sum(upper_bits, r >= 2, middle_bits, current_bits, 1'b1,
                                       k, cols), r - 1, k);
            end
            else if (c >= 1)
            begin
                push_count(box_sum(upper_bits, r >= 2, middle_bits, current_bits, 1'b1,
                                   c - 1, cols), r - 1, c - 1);
            end
        end

        // final cell flushes the whole last row
        if (last_row && last_col)
        begin
            for (int k = 0; k < cols; k++)
                push_count(box_sum(middle_bits, r >= 1, current_bits, current_bits, 1'b0,
                                   k, cols), r, k);
            beat = pending_counts.pop_back();
            beat.frame_end = 1'b1;
            pending_counts = {pending_counts, beat};
        end

        if (pending_counts.size() > size_before)
        begin
            beat = pending_counts.pop_back();
            beat.last_of_run = 1'b1;
            pending_counts = {pending_counts, beat};
        end

        if (last_col)
        begin
            next_col = 0;
            next_row = last_row ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        count_beat_t want;
        if (!rst_n)
        begin
            pending_counts.delete();
            upper_bits     = '0;
            middle_bits    = '0;
            current_bits   = '0;
            num_rows_q     = bgnc_pkg::NUM_ROWS_RESET;
            num_cols_q     = bgnc_pkg::NUM_COLS_RESET;
            next_row       = 0;
            next_col       = 0;
            errors         = 0;
            counts_pending <= 0;
            error_count    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    bgnc_pkg::REG_NUM_ROWS: num_rows_q = cfg.data;
                    bgnc_pkg::REG_NUM_COLS: num_cols_q = cfg.data[bgnc_pkg::NUM_COLS_W-1:0];
                    default: ;
                endcase
            end

            if (cells.valid && cells.ready)
                predict_box_sums(cells.mine);

            if (counts.valid && counts.ready)
            begin
                if (pending_counts.size() == 0)
                begin
                    $error("count beat for row %0d col %0d with no cell behind it",
                           counts.cell_row, counts.cell_col);
                    errors++;
                end
                else
                begin
                    want = pending_counts.pop_front();
                    check_field("neighbour_count", 16'(want.neighbour_count),
                                16'(counts.neighbour_count));
                    check_field("cell_row", 16'(want.cell_row), 16'(counts.cell_row));
                    check_field("cell_col", 16'(want.cell_col), 16'(counts.cell_col));
                    check_field("last_of_run", 16'(want.last_of_run), 16'(counts.last_of_run));
                    check_field("frame_end", 16'(want.frame_end), 16'(counts.frame_end));
                end
            end

            counts_pending <= pending_counts.size();
            error_count    <= errors;
        end
    end

endmodule

@@ test/binary_grid_neighbour_count_top_tb.sv @@
// ----------------------------------------------------------------------------
// binary_grid_neighbour_count_top_tb
// Streams binary grids through the box sum block under several grid sizes and
// flow control patterns: a directed opener, then random grids. The checker
// beside the block predicts every count; this module drives and judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module binary_grid_neighbour_count_top_tb;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;
    localparam int PHASE_CELLS      = 75;
    localparam logic [bgnc_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   counts_pending;
    int   error_count;
    int   cell_gap_pct;
    int   count_stall_pct;
    int   hold_requests;

    bgnc_cell_if  cells_ch();
    bgnc_count_if counts_ch();
    bgnc_cfg_if   cfg_ch();

    binary_grid_neighbour_count_top i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cells  (cells_ch),
        .counts (counts_ch),
        .cfg    (cfg_ch)
    );

    bgnc_box_sum_checker i_box_sum_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cells          (cells_ch),
        .counts         (counts_ch),
        .cfg            (cfg_ch),
        .counts_pending (counts_pending),
        .error_count    (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("binary_grid_neighbour_count_top verification failed");
        $finish;
    end

    // count receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        counts_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                hold_left = LONG_HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                counts_ch.ready <= 1'b0;
            end
            else
            begin
                counts_ch.ready <= ($urandom_range(99) >= count_stall_pct);
            end
        end
    end

    task automatic send_cell(input logic mine);
        while ($urandom_range(99) < cell_gap_pct)
        begin
            cells_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cells_ch.valid <= 1'b1;
        cells_ch.mine  <= mine;
        do @(posedge clk); while (!cells_ch.ready);
    endtask

    // drop valid and hold until every predicted count has come out
    task automatic wait_drained();
        cells_ch.valid <= 1'b0;
        do @(posedge clk); while (counts_pending != 0);
    endtask

    task automatic write_reg(input logic [bgnc_pkg::CFG_INDEX_W-1:0] index,
                             input logic [bgnc_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        // a cell with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [bgnc_pkg::CFG_DATA_W-1:0] rows_data,
                             input logic [bgnc_pkg::CFG_DATA_W-1:0] cols_data,
                             input int gap_pct, input int stall_pct,
                             input int mine_pct, input bit long_hold,
                             input bit mid_pause);
        write_reg(bgnc_pkg::REG_NUM_ROWS, rows_data);
        write_reg(bgnc_pkg::REG_NUM_COLS, cols_data);
        cell_gap_pct    = gap_pct;
        count_stall_pct = stall_pct;
        if (long_hold)
            hold_requests++;
        for (int n = 0; n < PHASE_CELLS; n++)
        begin
            if (mid_pause && n == PHASE_CELLS / 2)
                wait_drained();
            send_cell($urandom_range(99) < mine_pct);
        end
    endtask

    initial
    begin
        cell_gap_pct    = 0;
        count_stall_pct = 0;
        hold_requests   = 0;
        rst_n          <= 1'b0;
        cells_ch.valid <= 1'b0;
        cells_ch.mine  <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= bgnc_pkg::REG_NUM_ROWS;
        cfg_ch.data    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two one-cell grids at the reset sizes
        send_cell(1'b1);
        send_cell(1'b0);

        // full 3x3 grid: corner, edge and center sums up to nine
        write_reg(REG_SPARE, 13'h1FFF);
        write_reg(bgnc_pkg::REG_NUM_ROWS, 13'd3);
        write_reg(bgnc_pkg::REG_NUM_COLS, 13'd3);
        repeat (9) send_cell(1'b1);

        // shrink the columns mid-row, below the current position
        write_reg(bgnc_pkg::REG_NUM_ROWS, 13'd2);
        write_reg(bgnc_pkg::REG_NUM_COLS, 13'd4);
        send_cell(1'b1);
        send_cell(1'b0);
        write_reg(bgnc_pkg::REG_NUM_COLS, 13'd2);
        send_cell(1'b1);
        send_cell(1'b1);
        send_cell(1'b0);

        // shrink the rows mid-frame, below the current row
        write_reg(bgnc_pkg::REG_NUM_ROWS, 13'd4);
        repeat (4) send_cell(1'b1);
        write_reg(bgnc_pkg::REG_NUM_ROWS, 13'd2);
        send_cell(1'b0);
        send_cell(1'b1);

        run_phase(13'd5,    13'd7,    0,  0,  50, 1'b1, 1'b0);
        run_phase(13'd0,    13'h1FE0, 50, 0,  80, 1'b0, 1'b0);
        run_phase(13'h1FFF, 13'd0,    0,  50, 30, 1'b0, 1'b0);
        run_phase(13'd3,    13'd31,   16, 16, 95, 1'b0, 1'b1);
        run_phase(13'd4096, 13'd33,   0,  0,  10, 1'b0, 1'b0);
        run_phase(13'd2,    13'd4,    16, 16, 60, 1'b0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("binary_grid_neighbour_count_top verification clean");
        else
            $display("binary_grid_neighbour_count_top verification failed");
        $finish;
    end

endmodule
